// File: rtl/fsdc_pkg.sv
`timescale 1ns / 1ps

package fsdc_pkg;

    localparam int FRAC_BITS_DEF = 19;

    localparam int TGT_W  = 30;
    localparam int REF_W  = 26;
    localparam int DIV_W  = 5;
    localparam int INT_W  = 7;
    localparam int FRAC_W = 20;

    // The product target * divider stays below 2^33 whenever a divider is chosen.
    localparam int PROD_W = 33;
    // Partial remainder is below the doubled reference, which fits in 27 bits.
    localparam int REM_W  = REF_W + 1;
    localparam int TRY_W  = REM_W + 1;
    // Integer quotient bits kept: enough to tell 1..128 from larger values.
    localparam int IP_W   = 8;

    localparam logic [TGT_W-1:0] F_LIMIT_6  = TGT_W'(705000000);
    localparam logic [TGT_W-1:0] F_LIMIT_8  = TGT_W'(525000000);
    localparam logic [TGT_W-1:0] F_LIMIT_12 = TGT_W'(353000000);
    localparam logic [TGT_W-1:0] F_LIMIT_16 = TGT_W'(239000000);
    localparam logic [TGT_W-1:0] F_LIMIT_24 = TGT_W'(177000000);

    localparam logic [DIV_W-1:0] DIV_NONE = 5'd0;
    localparam logic [DIV_W-1:0] DIV_6    = 5'd6;
    localparam logic [DIV_W-1:0] DIV_8    = 5'd8;
    localparam logic [DIV_W-1:0] DIV_12   = 5'd12;
    localparam logic [DIV_W-1:0] DIV_16   = 5'd16;
    localparam logic [DIV_W-1:0] DIV_24   = 5'd24;

    localparam logic [REF_W-1:0]  REF_RESET = REF_W'(26000000);
    localparam logic [INT_W-1:0]  INT_MAX   = 7'h7f;
    localparam logic [FRAC_W-1:0] FRAC_MAX  = 20'hfffff;

    // Control that travels alongside each transaction through the pipeline.
    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] div;
        logic             err;
    } fsdc_tag_t;

endpackage

// File: rtl/fsdc_front.sv
`timescale 1ns / 1ps

module fsdc_front
    import fsdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [TGT_W-1:0]   target_hz,
    input  logic [REF_W-1:0]   reference_hz,
    output fsdc_tag_t          tag_reg,
    output logic [PROD_W-1:0]  prod_reg
);

    logic [DIV_W-1:0]       div;
    logic [TGT_W+DIV_W-1:0] prod_full;
    fsdc_tag_t              tag_next;

    // Output divider from the frequency thresholds; none at or above 705 MHz.
    always_comb
    begin
        priority if (target_hz < F_LIMIT_24) div = DIV_24;
        else if (target_hz < F_LIMIT_16)     div = DIV_16;
        else if (target_hz < F_LIMIT_12)     div = DIV_12;
        else if (target_hz < F_LIMIT_8)      div = DIV_8;
        else if (target_hz < F_LIMIT_6)      div = DIV_6;
        else                                 div = DIV_NONE;
    end

    assign prod_full = target_hz * (TGT_W+DIV_W)'(div);

    always_comb
    begin
        tag_next.valid = in_valid;
        tag_next.div   = div;
        tag_next.err   = (div == DIV_NONE) || (reference_hz == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
    end

endmodule

// File: rtl/fsdc_cell.sv
`timescale 1ns / 1ps

module fsdc_cell
    import fsdc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int IDX       = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [TRY_W-1:0]        den,
    input  fsdc_tag_t               tag_in,
    input  logic [PROD_W-1:0]       prod_in,
    input  logic [REM_W-1:0]        rem_in,
    input  logic [IP_W+FRAC_BITS-1:0] quo_in,
    input  logic                    ovf_in,
    output fsdc_tag_t               tag_reg,
    output logic [PROD_W-1:0]       prod_reg,
    output logic [REM_W-1:0]        rem_reg,
    output logic [IP_W+FRAC_BITS-1:0] quo_reg,
    output logic                    ovf_reg
);

    localparam int QW = IP_W + FRAC_BITS;
    // Cells ahead of the kept quotient bits only record whether any bit was set.
    localparam bit UPPER = (IDX < (PROD_W - IP_W));

    logic             dbit;
    logic [TRY_W-1:0] trial;
    logic [TRY_W-1:0] diff;
    logic             ge;
    logic [REM_W-1:0] rem_next;
    logic [QW-1:0]    quo_next;
    logic             ovf_next;

    generate
        if (IDX < PROD_W)
        begin : g_dividend
            assign dbit = prod_in[PROD_W-1-IDX];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end
    endgenerate

    assign trial    = {rem_in, dbit};
    assign ge       = (trial >= den);
    assign diff     = trial - den;
    assign rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];

    generate
        if (UPPER)
        begin : g_upper
            assign quo_next = quo_in;
            assign ovf_next = ovf_in | ge;
        end
        else
        begin : g_lower
            assign quo_next = {quo_in[QW-2:0], ge};
            assign ovf_next = ovf_in;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

// File: rtl/fsdc_back.sv
`timescale 1ns / 1ps

module fsdc_back
    import fsdc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  fsdc_tag_t                 tag_in,
    input  logic [IP_W+FRAC_BITS-1:0] quo_in,
    input  logic                      ovf_in,
    output logic                      valid_reg,
    output logic [DIV_W-1:0]          div_reg,
    output logic [INT_W-1:0]          n_reg,
    output logic [FRAC_W-1:0]         m_reg,
    output logic                      err_reg
);

    localparam int MW   = FRAC_BITS + 1;
    localparam int CMPW = (MW > FRAC_W) ? MW : FRAC_W;

    logic [IP_W-1:0] ip;
    logic [IP_W-1:0] n_wide;
    logic [CMPW-1:0] m_ext;
    logic            err;

    assign ip     = quo_in[IP_W+FRAC_BITS-1:FRAC_BITS];
    assign n_wide = ip - IP_W'(1);
    // m = ratio - n: the fraction bits with the one carried back in above them.
    assign m_ext  = CMPW'({1'b1, quo_in[FRAC_BITS-1:0]});

    assign err = tag_in.err || ovf_in || (ip == '0)
              || (n_wide > IP_W'(INT_MAX))
              || (m_ext > CMPW'(FRAC_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= tag_in.div;
            err_reg <= err;
            n_reg   <= err ? '0 : n_wide[INT_W-1:0];
            m_reg   <= err ? '0 : m_ext[FRAC_W-1:0];
        end
    end

endmodule

// File: rtl/fracn_synth_divider_calc_core.sv
`timescale 1ns / 1ps
// Pipeline: an accepted input transaction passes the front stage, one divider cell
// per quotient bit and the output stage before its result appears.
// Throughput: one transaction per cycle; the whole pipeline holds only while a result
// waits in the output register and the output side stalls.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the reference
// register with 26 MHz.

module fracn_synth_divider_calc_core
    import fsdc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [REF_W-1:0]   cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TGT_W-1:0]   target_hz,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DIV_W-1:0]   output_divider,
    output logic [INT_W-1:0]   feedback_int,
    output logic [FRAC_W-1:0]  fraction_word,
    output logic               range_error
);

    // The ratio target*divider/(2*reference) is formed by long division of the
    // product target*divider (followed by FRAC_BITS zero bits) by twice the
    // reference. Each cell of the chain takes one dividend bit and yields one
    // quotient bit. The first cells cover quotient weights above those of an
    // 8-bit integer part; any one set there flags an overflow.
    localparam int QW = IP_W + FRAC_BITS;
    localparam int NC = PROD_W + FRAC_BITS;

    logic [REF_W-1:0] reference_hz_reg;
    logic [TRY_W-1:0] den;
    logic             en;

    fsdc_tag_t         tag_c  [0:NC];
    logic [PROD_W-1:0] prod_c [0:NC];
    logic [REM_W-1:0]  rem_c  [0:NC];
    logic [QW-1:0]     quo_c  [0:NC];
    logic              ovf_c  [0:NC];

    // The user must write the reference register only while the block is idle, so that
    // every cell may read it directly; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_hz_reg <= REF_RESET;
        end
        else if (cfg_wr_en)
        begin
            reference_hz_reg <= cfg_wr_data;
        end
    end

    assign den = {1'b0, reference_hz_reg, 1'b0};

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    fsdc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .target_hz    (target_hz),
        .reference_hz (reference_hz_reg),
        .tag_reg      (tag_c[0]),
        .prod_reg     (prod_c[0])
    );

    // The partial remainder and quotient start at zero for every transaction.
    assign rem_c[0] = '0;
    assign quo_c[0] = '0;
    assign ovf_c[0] = 1'b0;

    generate
        for (genvar i = 0; i < NC; i++)
        begin : g_cell
            fsdc_cell #(
                .FRAC_BITS (FRAC_BITS),
                .IDX       (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .den      (den),
                .tag_in   (tag_c[i]),
                .prod_in  (prod_c[i]),
                .rem_in   (rem_c[i]),
                .quo_in   (quo_c[i]),
                .ovf_in   (ovf_c[i]),
                .tag_reg  (tag_c[i+1]),
                .prod_reg (prod_c[i+1]),
                .rem_reg  (rem_c[i+1]),
                .quo_reg  (quo_c[i+1]),
                .ovf_reg  (ovf_c[i+1])
            );
        end
    endgenerate

    // The final stage turns the quotient into n and m, applies the range checks
    // and acts as the output register.
    fsdc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tag_in    (tag_c[NC]),
        .quo_in    (quo_c[NC]),
        .ovf_in    (ovf_c[NC]),
        .valid_reg (out_valid),
        .div_reg   (output_divider),
        .n_reg     (feedback_int),
        .m_reg     (fraction_word),
        .err_reg   (range_error)
    );

    // An error result carries zero divider words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> feedback_int == '0 && fraction_word == '0)
    else $error("error result with non-zero divider words");

    // A good result always has one of the five output dividers.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_error |->
            output_divider == DIV_6 || output_divider == DIV_8 ||
            output_divider == DIV_12 || output_divider == DIV_16 ||
            output_divider == DIV_24)
    else $error("good result without a valid output divider");

    // A missing output divider can only come with an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && output_divider == DIV_NONE |-> range_error)
    else $error("frequency above range not flagged");

    // A result held back by the output side freezes the whole pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tag_c[NC]) && $stable(tag_c[0]))
    else $error("pipeline moved while the output was stalled");

endmodule
